@@ design/edge_gradient_magnitude_defines.svh @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude assertion macros
// Shared property templates, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EDGE_GRADIENT_MAGNITUDE_DEFINES_SVH
`define EDGE_GRADIENT_MAGNITUDE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// The consequent must hold in the cycle after the antecedent.
`define EGM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

@@ design/egm_pkg.sv @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude package
// Field widths, register indexes, fixed limits, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package egm_pkg;

    localparam int PIXEL_W    = 8;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 21;
    localparam int FW_W       = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int WIDTH_RESET  = 498;
    localparam int HEIGHT_RESET = 332;
    localparam int HEIGHT_MAX   = 4096;
    localparam int SAT_LIMIT    = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic OP_ROBERTS = 1'b0;
    localparam logic OP_PREWITT = 1'b1;

    typedef logic [PIXEL_W-1:0]       pixel_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [SUM_W-1:0]         sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } egm_state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic grad;
        logic square;
        logic root_step;
        logic out_load;
    } egm_cmd_t;

    typedef struct packed {
        logic skip;
        logic emit;
        logic root_last;
        logic out_free;
    } egm_status_t;

endpackage

@@ design/egm_pix_if.sv @@
// ----------------------------------------------------------------------------
// Pixel stream interface
// Carries one request word: a pixel or a flush tick.
// ----------------------------------------------------------------------------
interface egm_pix_if;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [egm_pkg::PIXEL_W-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink (input valid, input req_type, input pixel, output ready);
endinterface

@@ design/egm_res_if.sv @@
// ----------------------------------------------------------------------------
// Result stream interface
// Carries one result word: magnitude, both gradients and the frame end flag.
// ----------------------------------------------------------------------------
interface egm_res_if;
    logic                         valid;
    logic                         ready;
    logic [egm_pkg::PIXEL_W-1:0]  magnitude;
    logic signed [egm_pkg::GRAD_W-1:0] grad_x;
    logic signed [egm_pkg::GRAD_W-1:0] grad_y;
    logic                         last_of_frame;

    modport source (output valid, output magnitude, output grad_x, output grad_y,
                    output last_of_frame, input ready);
    modport sink (input valid, input magnitude, input grad_x, input grad_y,
                  input last_of_frame, output ready);
endinterface

@@ design/egm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries one register write word: register index and write data.
// ----------------------------------------------------------------------------
interface egm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [egm_pkg::CFG_IDX_W-1:0]  index;
    logic [egm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/edge_gradient_magnitude.sv @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude, Prewitt 3x3 or Roberts Cross 2x2
// A word that yields a result passes through load, gradient, square, the
// 8-step bit-serial square root and a done state that waits for a free
// output register. A word that yields no result returns to intake after load.
// Reset clears the controller, counters, window and output valid and restores
// the register defaults; the line stores are not cleared.
// ----------------------------------------------------------------------------
`include "edge_gradient_magnitude_defines.svh"

module edge_gradient_magnitude #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    egm_pix_if.sink   pixels,
    egm_res_if.source results,
    egm_cfg_if.sink   cfg
);

    egm_pkg::egm_cmd_t    cmd;
    egm_pkg::egm_status_t status;
    logic                 in_ready;
    logic                 pix_accept;

    assign pixels.ready = in_ready;
    assign cfg.ready    = 1'b1;
    assign pix_accept   = pixels.valid && pixels.ready;

    egm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    egm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_req_type       (pixels.req_type),
        .in_pixel          (pixels.pixel),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_ready         (results.ready),
        .out_valid         (results.valid),
        .out_magnitude     (results.magnitude),
        .out_grad_x        (results.grad_x),
        .out_grad_y        (results.grad_y),
        .out_last_of_frame (results.last_of_frame)
    );

    `EGM_ASSERT_NXT(a_accept_then_step, pix_accept, cmd.step)
    `EGM_ASSERT_IMP(a_no_intake_in_step, cmd.step, !pixels.ready)
    `EGM_ASSERT_NXT(a_load_shows_result, cmd.out_load, results.valid)
    `EGM_ASSERT_IMP(a_load_when_free, cmd.out_load, !results.valid || results.ready)

endmodule

@@ design/egm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module egm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/egm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude controller
// Sequences intake, window update, gradient, square, root and output load.
// ----------------------------------------------------------------------------
module egm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  egm_pkg::egm_status_t status,
    output egm_pkg::egm_cmd_t    cmd
);

    egm_pkg::egm_state_t state_reg;
    egm_pkg::egm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= egm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            egm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = egm_pkg::ST_LOAD;
                end
            end
            egm_pkg::ST_LOAD:
            begin
                cmd.step = 1'b1;
                if (status.skip || !status.emit)
                begin
                    state_next = egm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = egm_pkg::ST_GRAD;
                end
            end
            egm_pkg::ST_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = egm_pkg::ST_SQUARE;
            end
            egm_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = egm_pkg::ST_ROOT;
            end
            egm_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = egm_pkg::ST_DONE;
                end
            end
            egm_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = egm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/egm_datapath.sv @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude datapath
// Configuration, raster counters, line stores, 3x3 window, gradient masks,
// bit-serial square root and the output register.
// ----------------------------------------------------------------------------
module egm_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  egm_pkg::egm_cmd_t                  cmd,
    output egm_pkg::egm_status_t               status,
    input  logic                               in_req_type,
    input  egm_pkg::pixel_t                    in_pixel,
    input  logic                               cfg_valid,
    input  logic [egm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               out_ready,
    output logic                               out_valid,
    output egm_pkg::pixel_t                    out_magnitude,
    output egm_pkg::grad_t                     out_grad_x,
    output egm_pkg::grad_t                     out_grad_y,
    output logic                               out_last_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (egm_pkg::FW_W > WW) ? egm_pkg::FW_W : WW;
    localparam int HW = egm_pkg::HEIGHT_W;
    localparam int RESET_WIDTH =
        (egm_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : egm_pkg::WIDTH_RESET;
    localparam egm_pkg::sum_t SAT_SQ =
        egm_pkg::SUM_W'(egm_pkg::SAT_LIMIT * egm_pkg::SAT_LIMIT);

    // Configuration
    logic          op_sel_reg, op_sel_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [CW-1:0] fw_ext;
    logic [HW-1:0] fh;
    logic          geom_write;

    // Raster position of the next item
    logic [AW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [WW-1:0] col_inc;
    logic          col_wrap;

    // Captured request
    logic            req_reg, req_next;
    egm_pkg::pixel_t pix_reg, pix_next;

    // Window and border masks
    egm_pkg::pixel_t window_reg [9];
    egm_pkg::pixel_t window_next [9];
    logic top_off_reg, top_off_next;
    logic bot_off_reg, bot_off_next;
    logic left_off_reg, left_off_next;
    logic right_off_reg, right_off_next;
    logic last_reg, last_next;

    // Arithmetic
    egm_pkg::grad_t   gx_reg, gx_next;
    egm_pkg::grad_t   gy_reg, gy_next;
    egm_pkg::sum_t    sum_reg, sum_next;
    egm_pkg::pixel_t  root_reg, root_next;
    egm_pkg::pixel_t  bit_reg, bit_next;
    egm_pkg::pixel_t  trial;
    logic [2*egm_pkg::PIXEL_W-1:0] trial_sq;
    logic signed [2*egm_pkg::GRAD_W-1:0] sq_x;
    logic signed [2*egm_pkg::GRAD_W-1:0] sq_y;
    egm_pkg::pixel_t  m [9];
    logic [9:0]       col_left, col_right, row_top, row_bot;

    // Output register
    logic            out_valid_reg, out_valid_next;
    egm_pkg::pixel_t out_mag_reg, out_mag_next;
    egm_pkg::grad_t  out_gx_reg, out_gx_next;
    egm_pkg::grad_t  out_gy_reg, out_gy_next;
    logic            out_last_reg, out_last_next;

    // Step decode
    logic            in_frame;
    logic            col_zero;
    logic            last_now;
    logic            step_go;
    egm_pkg::pixel_t pix_eff;
    egm_pkg::pixel_t upper_rd, lower_rd;

    assign in_frame = row_reg < height_reg;
    assign col_zero = col_reg == '0;
    assign last_now = col_zero && (row_reg == HW'(height_reg + HW'(1)));
    assign pix_eff  = (req_reg == egm_pkg::REQ_PIXEL && in_frame) ? pix_reg : '0;

    always_comb
    begin
        status.skip      = (req_reg == egm_pkg::REQ_FLUSH) && in_frame;
        status.emit      = !(row_reg == '0 || (row_reg == HW'(1) && col_zero));
        status.root_last = bit_reg[0];
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign step_go = cmd.step && !status.skip;

    egm_ram #(
        .WIDTH (egm_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (step_go),
        .wr_addr (col_reg),
        .wr_data (lower_rd),
        .rd_en   (cmd.capture),
        .rd_addr (col_reg),
        .rd_data (upper_rd)
    );

    egm_ram #(
        .WIDTH (egm_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower (
        .clk     (clk),
        .wr_en   (step_go),
        .wr_addr (col_reg),
        .wr_data (pix_eff),
        .rd_en   (cmd.capture),
        .rd_addr (col_reg),
        .rd_data (lower_rd)
    );

    // Width is clamped to 2..MAX_WIDTH and height to 2..4096 when written.
    assign fw_ext     = CW'(cfg_data[egm_pkg::FW_W-1:0]);
    assign fh         = cfg_data[HW-1:0];
    assign geom_write = cfg_valid &&
                        (cfg_index == egm_pkg::CFG_WIDTH || cfg_index == egm_pkg::CFG_HEIGHT);

    always_comb
    begin
        op_sel_next = op_sel_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                egm_pkg::CFG_OPERATOR:
                begin
                    op_sel_next = cfg_data[0];
                end
                egm_pkg::CFG_WIDTH:
                begin
                    if (fw_ext < CW'(2))
                    begin
                        width_next = WW'(2);
                    end
                    else if (fw_ext > CW'(MAX_WIDTH))
                    begin
                        width_next = WW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WW'(fw_ext);
                    end
                end
                egm_pkg::CFG_HEIGHT:
                begin
                    if (fh < HW'(2))
                    begin
                        height_next = HW'(2);
                    end
                    else if (fh > HW'(egm_pkg::HEIGHT_MAX))
                    begin
                        height_next = HW'(egm_pkg::HEIGHT_MAX);
                    end
                    else
                    begin
                        height_next = fh;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign col_wrap = col_inc >= width_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (step_go)
        begin
            if (status.emit && last_now)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = HW'(row_reg + HW'(1));
            end
            else
            begin
                col_next = AW'(col_inc);
            end
        end
    end

    always_comb
    begin
        req_next = req_reg;
        pix_next = pix_reg;
        if (cmd.capture)
        begin
            req_next = in_req_type;
            pix_next = in_pixel;
        end
    end

    // The window shifts left by one column and takes the stored column on
    // the right: two rows up, one row up and the current pixel.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            window_next[i] = window_reg[i];
        end
        top_off_next   = top_off_reg;
        bot_off_next   = bot_off_reg;
        left_off_next  = left_off_reg;
        right_off_next = right_off_reg;
        last_next      = last_reg;
        if (step_go)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_next[k*3]   = window_reg[k*3+1];
                window_next[k*3+1] = window_reg[k*3+2];
            end
            window_next[2] = upper_rd;
            window_next[5] = lower_rd;
            window_next[8] = pix_eff;
            top_off_next   = col_zero ? (row_reg == HW'(2)) : (row_reg == HW'(1));
            bot_off_next   = col_zero ? last_now : (row_reg == height_reg);
            left_off_next  = col_reg == AW'(1);
            right_off_next = col_zero;
            last_next      = last_now;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((k == 0 && top_off_reg) || (k == 2 && bot_off_reg) ||
                    (j == 0 && left_off_reg) || (j == 2 && right_off_reg))
                begin
                    m[k*3+j] = '0;
                end
                else
                begin
                    m[k*3+j] = window_reg[k*3+j];
                end
            end
        end
        col_left  = 10'(m[0]) + 10'(m[3]) + 10'(m[6]);
        col_right = 10'(m[2]) + 10'(m[5]) + 10'(m[8]);
        row_top   = 10'(m[0]) + 10'(m[1]) + 10'(m[2]);
        row_bot   = 10'(m[6]) + 10'(m[7]) + 10'(m[8]);
    end

    always_comb
    begin
        gx_next = gx_reg;
        gy_next = gy_reg;
        if (cmd.grad)
        begin
            if (op_sel_reg == egm_pkg::OP_PREWITT)
            begin
                gx_next = $signed({1'b0, col_left}) - $signed({1'b0, col_right});
                gy_next = $signed({1'b0, row_top}) - $signed({1'b0, row_bot});
            end
            else
            begin
                gx_next = $signed({3'b000, m[4]}) - $signed({3'b000, m[8]});
                gy_next = $signed({3'b000, m[5]}) - $signed({3'b000, m[7]});
            end
        end
    end

    assign sq_x     = gx_reg * gx_reg;
    assign sq_y     = gy_reg * gy_reg;
    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    // One result bit per cycle, most significant first.
    always_comb
    begin
        sum_next  = sum_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (cmd.square)
        begin
            sum_next  = egm_pkg::SUM_W'(sq_x) + egm_pkg::SUM_W'(sq_y);
            root_next = '0;
            bit_next  = {1'b1, {(egm_pkg::PIXEL_W-1){1'b0}}};
        end
        else if (cmd.root_step)
        begin
            if (egm_pkg::SUM_W'(trial_sq) <= sum_reg)
            begin
                root_next = trial;
            end
            bit_next = bit_reg >> 1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_mag_next   = out_mag_reg;
        out_gx_next    = out_gx_reg;
        out_gy_next    = out_gy_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_mag_next   = (sum_reg >= SAT_SQ) ? egm_pkg::PIXEL_W'(egm_pkg::SAT_LIMIT)
                                                 : root_reg;
            out_gx_next    = gx_reg;
            out_gy_next    = gy_reg;
            out_last_next  = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_sel_reg    <= egm_pkg::OP_PREWITT;
            width_reg     <= WW'(RESET_WIDTH);
            height_reg    <= HW'(egm_pkg::HEIGHT_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            op_sel_reg    <= op_sel_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        pix_reg       <= pix_next;
        top_off_reg   <= top_off_next;
        bot_off_reg   <= bot_off_next;
        left_off_reg  <= left_off_next;
        right_off_reg <= right_off_next;
        last_reg      <= last_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        sum_reg       <= sum_next;
        root_reg      <= root_next;
        out_mag_reg   <= out_mag_next;
        out_gx_reg    <= out_gx_next;
        out_gy_reg    <= out_gy_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_magnitude     = out_mag_reg;
    assign out_grad_x        = out_gx_reg;
    assign out_grad_y        = out_gy_reg;
    assign out_last_of_frame = out_last_reg;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Edge gradient magnitude testbench
// Streams luma words and flush ticks through the pixel channel, with random
// gaps on the sender and random stalls on the result channel. A built-in
// gradient predictor tracks the line stores, the window and the frame
// counters, and every result word is checked field by field in order. A short
// directed table covers corners, both operators, ignored flushes, pixels
// during drain and the unused register index. Random phases with random
// geometry and operator follow, including the widest rows and the tallest
// frame height.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_WORDS = 1000;
    localparam int QUIET_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam logic [egm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        egm_pkg::pixel_t magnitude;
        egm_pkg::grad_t  grad_x;
        egm_pkg::grad_t  grad_y;
        logic            last_of_frame;
    } grad_word_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [egm_pkg::CFG_IDX_W-1:0]  index;
        logic                           req;
        logic [egm_pkg::CFG_DATA_W-1:0] data;
        logic                           checked;
        grad_word_t                     expected;
    } stim_row_t;

    localparam grad_word_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 35;

    // All-255 corners of a 2x2 frame, the same frame under Roberts Cross, and
    // the full positive horizontal swing of Prewitt at the center of a 3x3.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_WRITE, egm_pkg::CFG_WIDTH,    egm_pkg::REQ_PIXEL, 13'd2,   1'b0, NO_RESULT},
        '{ROW_WRITE, egm_pkg::CFG_HEIGHT,   egm_pkg::REQ_PIXEL, 13'd2,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b1,
          '{8'd255, -11'sd510, -11'sd510, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b1,
          '{8'd255, 11'sd510, -11'sd510, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b1,
          '{8'd255, -11'sd510, 11'sd510, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b1,
          '{8'd255, 11'sd510, 11'sd510, 1'b1}},
        '{ROW_WRITE, egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'(egm_pkg::OP_ROBERTS),
          1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_UNUSED,            egm_pkg::REQ_PIXEL, 13'h1555, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b1,
          '{8'd0, 11'sd0, 11'sd0, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b1,
          '{8'd255, 11'sd255, -11'sd255, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b1,
          '{8'd255, 11'sd255, 11'sd255, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b1,
          '{8'd255, 11'sd255, 11'sd0, 1'b1}},
        '{ROW_WRITE, egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'(egm_pkg::OP_PREWITT),
          1'b0, NO_RESULT},
        '{ROW_WRITE, egm_pkg::CFG_WIDTH,    egm_pkg::REQ_PIXEL, 13'd3,   1'b0, NO_RESULT},
        '{ROW_WRITE, egm_pkg::CFG_HEIGHT,   egm_pkg::REQ_PIXEL, 13'd3,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd255, 1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_PIXEL, 13'd0,   1'b1,
          '{8'd255, 11'sd765, 11'sd0, 1'b0}},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b0, NO_RESULT},
        '{ROW_WORD,  egm_pkg::CFG_OPERATOR, egm_pkg::REQ_FLUSH, 13'd0,   1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    egm_pix_if pix_bus ();
    egm_res_if res_bus ();
    egm_cfg_if cfg_bus ();

    edge_gradient_magnitude dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_bus),
        .results (res_bus),
        .cfg     (cfg_bus)
    );

    logic                         sel_op;
    logic [egm_pkg::FW_W-1:0]     reg_width;
    logic [egm_pkg::HEIGHT_W-1:0] reg_height;
    egm_pkg::pixel_t              ls_upper [LINE_DEPTH];
    egm_pkg::pixel_t              ls_lower [LINE_DEPTH];
    egm_pkg::pixel_t              win [9];
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int unsigned                  emitted;

    grad_word_t  pending_gradients [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned random_words = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;

    always #5 clk = ~clk;

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 6) == 0)
        begin
            return $urandom_range(8, 20);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic egm_pkg::pixel_t pick_pixel();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return '1;
        end
        return egm_pkg::pixel_t'($urandom_range(0, 255));
    endfunction

    function automatic void reset_predictor();
        sel_op = egm_pkg::OP_PREWITT;
        reg_width = egm_pkg::FW_W'(egm_pkg::WIDTH_RESET);
        reg_height = egm_pkg::HEIGHT_W'(egm_pkg::HEIGHT_RESET);
        foreach (ls_upper[i])
        begin
            ls_upper[i] = '0;
            ls_lower[i] = '0;
        end
        foreach (win[i])
        begin
            win[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
    endfunction

    function automatic void frame_geometry(output int unsigned w, output int unsigned h);
        w = reg_width;
        h = reg_height;
        if (w < 2)
        begin
            w = 2;
        end
        if (w > LINE_DEPTH)
        begin
            w = LINE_DEPTH;
        end
        if (h < 2)
        begin
            h = 2;
        end
        if (h > egm_pkg::HEIGHT_MAX)
        begin
            h = egm_pkg::HEIGHT_MAX;
        end
    endfunction

    function automatic egm_pkg::pixel_t root_saturated(input int unsigned s);
        int unsigned r;
        int unsigned b;
        if (s >= egm_pkg::SAT_LIMIT * egm_pkg::SAT_LIMIT)
        begin
            return egm_pkg::pixel_t'(egm_pkg::SAT_LIMIT);
        end
        r = 0;
        for (b = 128; b != 0; b = b >> 1)
        begin
            if ((r + b) * (r + b) <= s)
            begin
                r = r + b;
            end
        end
        return egm_pkg::pixel_t'(r);
    endfunction

    // Advances the line stores, window and counters by one accepted word, unless it
    // is an ignored flush, and returns 1 when the word releases a result.
    function automatic bit compute_gradient(input logic req, input egm_pkg::pixel_t pix_in,
                                            output grad_word_t res, output bit dropped);
        int unsigned     w;
        int unsigned     h;
        int unsigned     total;
        int unsigned     pos;
        int unsigned     x;
        int unsigned     rowin;
        int unsigned     r;
        int unsigned     c;
        int unsigned     k;
        int unsigned     j;
        egm_pkg::pixel_t top;
        egm_pkg::pixel_t mid;
        egm_pkg::pixel_t pv;
        int              m [3][3];
        int              gx;
        int              gy;
        bit              off;
        frame_geometry(w, h);
        total = w * h;
        pos = row_pos * w + col_pos;
        x = col_pos;
        rowin = row_pos;
        res = '0;
        dropped = (req == egm_pkg::REQ_FLUSH) && (pos < total);
        if (dropped)
        begin
            return 1'b0;
        end
        pv = (req == egm_pkg::REQ_PIXEL && pos < total) ? pix_in : '0;
        top = ls_upper[x];
        mid = ls_lower[x];
        ls_upper[x] = mid;
        ls_lower[x] = pv;
        for (k = 0; k < 3; k++)
        begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = pv;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (pos < w + 1)
        begin
            return 1'b0;
        end
        if (x == 0)
        begin
            c = w - 1;
            r = rowin - 2;
        end
        else
        begin
            c = x - 1;
            r = rowin - 1;
        end
        for (k = 0; k < 3; k++)
        begin
            for (j = 0; j < 3; j++)
            begin
                off = (k == 0 && r == 0) || (k == 2 && r == h - 1) ||
                      (j == 0 && c == 0) || (j == 2 && c == w - 1);
                m[k][j] = off ? 0 : int'(win[k * 3 + j]);
            end
        end
        if (sel_op == egm_pkg::OP_PREWITT)
        begin
            gx = (m[0][0] + m[1][0] + m[2][0]) - (m[0][2] + m[1][2] + m[2][2]);
            gy = (m[0][0] + m[0][1] + m[0][2]) - (m[2][0] + m[2][1] + m[2][2]);
        end
        else
        begin
            gx = m[1][1] - m[2][2];
            gy = m[1][2] - m[2][1];
        end
        res.magnitude = root_saturated(int'(gx * gx + gy * gy));
        res.grad_x = egm_pkg::grad_t'(gx);
        res.grad_y = egm_pkg::grad_t'(gy);
        res.last_of_frame = (emitted == total - 1);
        emitted++;
        if (res.last_of_frame)
        begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end
        return 1'b1;
    endfunction

    task automatic drain_wait();
        pix_bus.valid <= 1'b0;
        while (pending_gradients.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [egm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [egm_pkg::CFG_DATA_W-1:0] value);
        drain_wait();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        if (idx == egm_pkg::CFG_OPERATOR)
        begin
            sel_op = value[0];
        end
        else if (idx == egm_pkg::CFG_WIDTH || idx == egm_pkg::CFG_HEIGHT)
        begin
            if (idx == egm_pkg::CFG_WIDTH)
            begin
                reg_width = value[egm_pkg::FW_W-1:0];
            end
            else
            begin
                reg_height = value[egm_pkg::HEIGHT_W-1:0];
            end
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end
    endtask

    task automatic send_word(input logic req, input egm_pkg::pixel_t pv, input bit checked,
                             input grad_word_t typed, output bit dropped,
                             output bit closed);
        int unsigned gap;
        grad_word_t  predicted;
        bit          produced;
        gap = 0;
        if (!sender_calm && $urandom_range(0, 2) == 0)
        begin
            gap = gap_len();
        end
        if (gap != 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.req_type <= req;
        pix_bus.pixel <= pv;
        do
            @(posedge clk);
        while (pix_bus.ready !== 1'b1);
        produced = compute_gradient(req, pv, predicted, dropped);
        closed = produced && predicted.last_of_frame;
        if (checked)
        begin
            pending_gradients.push_back(typed);
        end
        else if (produced)
        begin
            pending_gradients.push_back(predicted);
        end
    endtask

    // Mostly well-formed frames: pixels while the frame fills, flush ticks
    // while it drains, with a few ignored flushes and drain pixels mixed in.
    task automatic send_random_word(output bit dropped, output bit closed);
        int unsigned w;
        int unsigned h;
        logic        req;
        frame_geometry(w, h);
        if ($urandom_range(0, 49) == 0)
        begin
            drain_wait();
        end
        if (row_pos * w + col_pos < w * h)
        begin
            req = ($urandom_range(0, 15) == 0) ? egm_pkg::REQ_FLUSH : egm_pkg::REQ_PIXEL;
        end
        else
        begin
            req = ($urandom_range(0, 9) == 0) ? egm_pkg::REQ_PIXEL : egm_pkg::REQ_FLUSH;
        end
        send_word(req, pick_pixel(), 1'b0, NO_RESULT, dropped, closed);
    endtask

    task automatic run_phase(input logic op, input bit geom,
                             input logic [egm_pkg::CFG_DATA_W-1:0] wv,
                             input logic [egm_pkg::CFG_DATA_W-1:0] hv,
                             input int unsigned frames, input int unsigned extra);
        int unsigned done_frames;
        bit          dropped;
        bit          closed;
        write_register(egm_pkg::CFG_OPERATOR, egm_pkg::CFG_DATA_W'(op));
        if (geom)
        begin
            write_register(egm_pkg::CFG_WIDTH, wv);
            write_register(egm_pkg::CFG_HEIGHT, hv);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            write_register(CFG_UNUSED, egm_pkg::CFG_DATA_W'($urandom));
        end
        sender_calm = ($urandom_range(0, 3) == 0);
        done_frames = 0;
        while (done_frames < frames)
        begin
            send_random_word(dropped, closed);
            done_frames += closed;
            random_words += !dropped;
        end
        repeat (extra)
        begin
            send_random_word(dropped, closed);
            random_words += !dropped;
        end
    endtask

    always @(posedge clk)
    begin
        if (calm_left == 0)
        begin
            receiver_calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 300);
        end
        else
        begin
            calm_left--;
        end
        if (stall_left != 0)
        begin
            res_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if (!receiver_calm && $urandom_range(0, 2) == 0)
            begin
                stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        grad_word_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_gradients.size() == 0)
            begin
                $error("result word with nothing pending: magnitude %0d", res_bus.magnitude);
                mismatches++;
            end
            else
            begin
                want = pending_gradients.pop_front();
                if (res_bus.magnitude !== want.magnitude)
                begin
                    $error("magnitude: expected %0d, got %0d", want.magnitude,
                           res_bus.magnitude);
                    mismatches++;
                end
                if (res_bus.grad_x !== want.grad_x)
                begin
                    $error("grad_x: expected %0d, got %0d", want.grad_x, res_bus.grad_x);
                    mismatches++;
                end
                if (res_bus.grad_y !== want.grad_y)
                begin
                    $error("grad_y: expected %0d, got %0d", want.grad_y, res_bus.grad_y);
                    mismatches++;
                end
                if (res_bus.last_of_frame !== want.last_of_frame)
                begin
                    $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
                           res_bus.last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned                    w;
        int unsigned                    h;
        int                             sel;
        bit                             geom;
        bit                             dropped;
        bit                             closed;
        logic [egm_pkg::CFG_DATA_W-1:0] wv;
        logic [egm_pkg::CFG_DATA_W-1:0] hv;
        clk = 1'b0;
        rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.req_type = egm_pkg::REQ_PIXEL;
        pix_bus.pixel = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = egm_pkg::CFG_OPERATOR;
        cfg_bus.data = '0;
        res_bus.ready = 1'b0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                write_register(DIRECTED[i].index, DIRECTED[i].data);
            end
            else
            begin
                send_word(DIRECTED[i].req, DIRECTED[i].data[egm_pkg::PIXEL_W-1:0],
                          DIRECTED[i].checked, DIRECTED[i].expected, dropped, closed);
            end
        end

        // Widest rows and tallest frame, both reached through clamped values.
        run_phase(egm_pkg::OP_PREWITT, 1'b1, 13'h07FF, 13'd0, 0, 200);
        run_phase(egm_pkg::OP_ROBERTS, 1'b1, 13'd1, 13'h1FFF, 0, 100);

        while (random_words < RANDOM_WORDS)
        begin
            frame_geometry(w, h);
            geom = (w * h > 200) || ($urandom_range(0, 1) == 1);
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                wv = egm_pkg::CFG_DATA_W'($urandom_range(0, 1));
            end
            else if (sel == 1)
            begin
                wv = egm_pkg::CFG_DATA_W'($urandom_range(9, 40));
            end
            else
            begin
                wv = egm_pkg::CFG_DATA_W'($urandom_range(2, 8));
            end
            wv[egm_pkg::CFG_DATA_W-1:egm_pkg::FW_W] = 2'($urandom_range(0, 3));
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                hv = egm_pkg::CFG_DATA_W'($urandom_range(0, 1));
            end
            else if (sel == 1)
            begin
                hv = egm_pkg::CFG_DATA_W'($urandom_range(7, 12));
            end
            else
            begin
                hv = egm_pkg::CFG_DATA_W'($urandom_range(2, 6));
            end
            run_phase(logic'($urandom_range(0, 1)), geom, wv, hv, $urandom_range(1, 2),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0);
        end

        drain_wait();
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
